// File: src/flat_key_value_table_unit_defines.svh
// Assertion macros for the flat key/value table unit.
// Uses the enclosing module's clk and arst_n; no other dependencies.
`ifndef FLAT_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define FLAT_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define FKVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/flat_kvt_pkg.sv
// Shared types and codes for the flat key/value table unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package flat_kvt_pkg;

	// Fixed field widths of the request and response streams
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ROWS_W   = 9;
	localparam int unsigned FOUND_W  = 32;
	localparam int unsigned S_DATA_W = 64;
	localparam int unsigned M_DATA_W = 48;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd3;

	// Response status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ORDER     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INS_CHK,
		S_DEL_RD,
		S_DEL_CMP,
		S_DEL_MOVE,
		S_DONE
	} state_t;

endpackage

// File: src/flat_kvt_store.sv
// Key and value row memories for the flat key/value table unit.
// Synchronous (registered) read; no package dependencies.
`timescale 1ns / 1ps

module flat_kvt_store #(
	parameter int unsigned DEPTH      = 256,
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic [KEY_BITS-1:0]          rd_key,
	output logic [VALUE_BITS-1:0]        rd_val,
	input  logic                         wr_key_en,
	input  logic                         wr_val_en,
	input  logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  logic [KEY_BITS-1:0]          wr_key,
	input  logic [VALUE_BITS-1:0]        wr_val
);

	logic [KEY_BITS-1:0]   key_mem [DEPTH];
	logic [VALUE_BITS-1:0] val_mem [DEPTH];

	// Write ports
	always_ff @(posedge clk) begin
		if (wr_key_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (wr_val_en) begin
			val_mem[wr_addr] <= wr_val;
		end
	end

	// Registered read port shared by both memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_val <= val_mem[rd_addr];
		end
	end

endmodule

// File: src/flat_key_value_table_unit.sv
// Top level of the flat key/value table unit: request sequencer and output register.
// Depends on flat_kvt_pkg, flat_kvt_store and flat_key_value_table_unit_defines.svh.
`timescale 1ns / 1ps
`include "flat_key_value_table_unit_defines.svh"

// Channel   | Signals                      | Contents
// ----------+------------------------------+-----------------------------------------
// cfg       | cfg_wr_en, cfg_wr_data       | sorted_order bit
// request   | s_tvalid/s_tready/s_tdata/u  | tuser: mode; tdata: key, value
// response  | m_tvalid/m_tready/m_tdata/u  | tuser: status; tdata: rows_affected, found
//
// One request at a time; a get ends at its first match, an update writes every matching row and
// falls back to insert when no row matches, and a delete removes every matching row by moving
// the last row into its place, or is refused when sorted_order is set. All steps share the
// single read port of the row memories.
// Reset clears the row count, the sorted_order bit and the handshake state; the memories need no
// clearing pass. A stalled response holds in the output register while the next request runs.
module flat_key_value_table_unit #(
	parameter int unsigned TABLE_DEPTH = 256,
	parameter int unsigned KEY_BITS    = 32,
	parameter int unsigned VALUE_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [flat_kvt_pkg::S_DATA_W-1:0] s_tdata,  // key[31:0], value[63:32]
	input  logic [flat_kvt_pkg::MODE_W-1:0]   s_tuser,  // mode[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [flat_kvt_pkg::M_DATA_W-1:0] m_tdata,  // rows_affected[8:0], found_value[40:9]
	output logic [flat_kvt_pkg::STATUS_W-1:0] m_tuser   // status[1:0]
);

	import flat_kvt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	logic                  sorted_q;
	logic [CW-1:0]         cnt_q;
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         rows_q;
	logic [STATUS_W-1:0]   status_q;
	logic [VALUE_BITS-1:0] found_q;
	logic                  chk_vld_q;
	logic [AW-1:0]         chk_idx_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [ROWS_W-1:0]     out_rows_q;
	logic [FOUND_W-1:0]    out_found_q;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  wr_key_en;
	logic                  wr_val_en;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;

	logic                  s_acc;
	logic                  out_free;
	logic                  out_load;
	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] val_in;
	logic [AW-1:0]         last_addr;
	logic                  scan_issue;
	logic                  scan_hit;
	logic                  scan_end;
	logic                  key_match;
	logic                  order_bad;
	logic                  tbl_full;
	logic                  ins_ok;
	logic                  del_end;

	// Request decode and shared conditions
	assign s_tready   = (state_q == S_IDLE);
	assign s_acc      = s_tvalid && s_tready;
	assign key_in     = KEY_BITS'(s_tdata[KEY_W-1:0]);
	assign val_in     = VALUE_BITS'(s_tdata[KEY_W +: VALUE_W]);
	assign last_addr  = AW'(cnt_q - CW'(1));
	assign key_match  = (rd_key == key_q);
	assign scan_issue = (idx_q < cnt_q);
	assign scan_hit   = chk_vld_q && key_match;
	assign scan_end   = !scan_issue && !chk_vld_q;
	assign order_bad  = sorted_q && (cnt_q != '0) && (key_q < rd_key);
	assign tbl_full   = (cnt_q == CW'(TABLE_DEPTH));
	assign ins_ok     = !order_bad && !tbl_full;
	assign del_end    = (idx_q >= cnt_q);
	assign out_free   = !out_valid_q || m_tready;
	assign out_load   = (state_q == S_DONE) && out_free;

	// Row memories
	flat_kvt_store #(
		.DEPTH      (TABLE_DEPTH),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_key    (rd_key),
		.rd_val    (rd_val),
		.wr_key_en (wr_key_en),
		.wr_val_en (wr_val_en),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_val    (wr_val)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (s_tuser)
						MODE_INSERT: state_d = S_INS_CHK;
						MODE_GET:    state_d = S_SCAN;
						MODE_DELETE: state_d = sorted_q ? S_DONE : S_DEL_RD;
						MODE_UPDATE: state_d = S_SCAN;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit && (mode_q == MODE_GET)) begin
					state_d = S_DONE;
				end else if (scan_end) begin
					state_d = ((mode_q == MODE_UPDATE) && (rows_q == '0)) ? S_INS_CHK : S_DONE;
				end
			end
			S_INS_CHK:  state_d = S_DONE;
			S_DEL_RD:   state_d = del_end ? S_DONE : S_DEL_CMP;
			S_DEL_CMP:  state_d = key_match ? S_DEL_MOVE : S_DEL_RD;
			S_DEL_MOVE: state_d = S_DEL_RD;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory port control per state
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = last_addr;
		wr_key_en = 1'b0;
		wr_val_en = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_key    = rd_key;
		wr_val    = rd_val;
		case (state_q)
			S_IDLE: begin
				// fetch the last row's key for the order check of an insert
				rd_en = 1'b1;
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_issue ? idx_q[AW-1:0] : last_addr;
				if (scan_hit && (mode_q == MODE_UPDATE)) begin
					wr_val_en = 1'b1;
					wr_addr   = chk_idx_q;
					wr_val    = val_q;
				end
			end
			S_INS_CHK: begin
				wr_key_en = ins_ok;
				wr_val_en = ins_ok;
				wr_addr   = cnt_q[AW-1:0];
				wr_key    = key_q;
				wr_val    = val_q;
			end
			S_DEL_RD: begin
				rd_en   = !del_end;
				rd_addr = idx_q[AW-1:0];
			end
			S_DEL_CMP: begin
				// fetch the last row to fill the hole
				rd_en = key_match;
			end
			S_DEL_MOVE: begin
				wr_key_en = 1'b1;
				wr_val_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sorted_q  <= 1'b0;
			cnt_q     <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				sorted_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE:     chk_vld_q <= 1'b0;
				S_SCAN:     chk_vld_q <= scan_issue;
				S_INS_CHK:  cnt_q <= ins_ok ? cnt_q + CW'(1) : cnt_q;
				S_DEL_MOVE: cnt_q <= cnt_q - CW'(1);
				default:    chk_vld_q <= 1'b0;
			endcase
		end
	end

	// Request context, scan position and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					mode_q   <= s_tuser;
					key_q    <= key_in;
					val_q    <= val_in;
					idx_q    <= '0;
					rows_q   <= '0;
					found_q  <= '0;
					status_q <= STAT_ORDER;
				end
			end
			S_SCAN: begin
				chk_idx_q <= idx_q[AW-1:0];
				if (scan_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (scan_hit && (mode_q == MODE_GET)) begin
					status_q <= STAT_OK;
					rows_q   <= CW'(1);
					found_q  <= rd_val;
				end else if (scan_hit) begin
					rows_q <= rows_q + CW'(1);
				end else if (scan_end) begin
					status_q <= (rows_q == '0) ? STAT_NOT_FOUND : STAT_OK;
				end
			end
			S_INS_CHK: begin
				if (order_bad) begin
					status_q <= STAT_ORDER;
				end else if (tbl_full) begin
					status_q <= STAT_FULL;
				end else begin
					status_q <= STAT_OK;
				end
				rows_q <= ins_ok ? CW'(1) : '0;
			end
			S_DEL_RD: begin
				if (del_end) begin
					status_q <= (rows_q == '0) ? STAT_NOT_FOUND : STAT_OK;
				end
			end
			S_DEL_CMP: begin
				if (!key_match) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_DEL_MOVE: begin
				rows_q <= rows_q + CW'(1);
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// Output register: hold until the response is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_rows_q   <= ROWS_W'(rows_q);
			out_found_q  <= FOUND_W'(found_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = M_DATA_W'({out_found_q, out_rows_q});

	// Row count never exceeds the table depth
	`FKVT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "row count above depth")
	// A successful insert grows the table by exactly one row
	`FKVT_ASSERT_NEXT(a_ins_grow, (state_q == S_INS_CHK) && ins_ok, cnt_q == $past(cnt_q) + CW'(1), "insert did not add one row")
	// Each row move shrinks the table by one
	`FKVT_ASSERT_NEXT(a_del_shrink, state_q == S_DEL_MOVE, cnt_q == $past(cnt_q) - CW'(1), "delete move did not drop one row")
	// An ok response always reports at least one row
	`FKVT_ASSERT_NOW(a_ok_rows, (state_q == S_DONE) && (status_q == STAT_OK), rows_q != '0, "ok status with no rows")
	// A stalled response keeps the sequencer waiting
	`FKVT_ASSERT_NEXT(a_done_hold, (state_q == S_DONE) && out_valid_q && !m_tready, state_q == S_DONE, "result dropped under stall")

endmodule
